/* hw/rtl/ewv_pkg.sv */
package ewv_pkg;

    localparam int WINDOW_DEFAULT = 16;

    localparam int COUNT_W    = 32;
    localparam int MS_W       = 16;
    localparam int TICK_SUM_W = 40;
    localparam int TIME_SUM_W = 24;
    localparam int VEL_W      = 40;

    // |tick_sum| * 256000 stays below 2^57, kept even for the radix-4 divider
    localparam int NUM_W       = 58;
    localparam int DIV_STEPS   = NUM_W / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    localparam logic CMD_SAMPLE    = 1'b0;
    localparam logic CMD_RESET_POS = 1'b1;

    typedef struct packed {
        logic                      command;
        logic signed [COUNT_W-1:0] encoder_count;
        logic        [MS_W-1:0]    elapsed_ms;
    } in_t;

    typedef struct packed {
        logic signed [VEL_W-1:0]   velocity_q8;
        logic                      velocity_valid;
        logic signed [COUNT_W-1:0] position_ticks;
    } out_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic take_abs;
        logic scale;
        logic div_start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } sts_t;

endpackage

/* hw/rtl/ewv_divider.sv */
module ewv_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ewv_pkg::NUM_W-1:0]         dividend,
    input  logic [ewv_pkg::TIME_SUM_W-1:0]    divisor,
    output logic                              busy,
    output logic [ewv_pkg::NUM_W-1:0]         quotient
);
    import ewv_pkg::*;

    logic                    busy_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic [NUM_W-1:0]        quo_reg;
    logic [TIME_SUM_W-1:0]   rem_reg;

    logic [NUM_W-1:0]        quo_next;
    logic [TIME_SUM_W-1:0]   rem_next;
    logic [TIME_SUM_W:0]     t1;
    logic [TIME_SUM_W:0]     t2;
    logic [TIME_SUM_W:0]     dext;
    logic [TIME_SUM_W-1:0]   r1;
    logic                    b1;
    logic                    b2;

    // two restoring steps per cycle
    always_comb
    begin
        dext     = {1'b0, divisor};
        t1       = {rem_reg, quo_reg[NUM_W-1]};
        b1       = (t1 >= dext);
        r1       = b1 ? TIME_SUM_W'(t1 - dext) : t1[TIME_SUM_W-1:0];
        t2       = {r1, quo_reg[NUM_W-2]};
        b2       = (t2 >= dext);
        rem_next = b2 ? TIME_SUM_W'(t2 - dext) : t2[TIME_SUM_W-1:0];
        quo_next = {quo_reg[NUM_W-3:0], b1, b2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/ewv_datapath.sv */
module ewv_datapath #(
    parameter int WINDOW = ewv_pkg::WINDOW_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ewv_pkg::in_t  in_data,
    input  ewv_pkg::cmd_t cmd,
    output ewv_pkg::sts_t sts,
    output ewv_pkg::out_t out_data
);
    import ewv_pkg::*;

    localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int ENTRY_W = COUNT_W + MS_W;

    logic [ENTRY_W-1:0]           ring_mem [WINDOW];
    logic [ENTRY_W-1:0]           rd_reg;

    logic [PTR_W-1:0]             ptr_reg;
    logic                         full_reg;
    logic signed [COUNT_W-1:0]    last_count_reg;
    logic signed [TICK_SUM_W-1:0] tick_sum_reg;
    logic [TIME_SUM_W-1:0]        time_sum_reg;

    logic signed [COUNT_W-1:0]    count_reg;
    logic [MS_W-1:0]              ms_reg;
    logic [TICK_SUM_W-1:0]        abs_reg;
    logic                         neg_reg;
    logic [NUM_W-1:0]             mag_reg;
    out_t                         out_reg;

    logic signed [COUNT_W-1:0]    delta;
    logic signed [COUNT_W-1:0]    evict_delta;
    logic [MS_W-1:0]              evict_ms;
    logic [NUM_W-1:0]             abs_ext;
    logic [NUM_W-1:0]             mag_next;
    logic                         div_busy;
    logic [NUM_W-1:0]             quotient;
    logic signed [VEL_W-1:0]      vel;
    out_t                         out_next;

    always_comb
    begin
        delta       = count_reg - last_count_reg;
        evict_delta = full_reg ? rd_reg[ENTRY_W-1:MS_W] : '0;
        evict_ms    = full_reg ? rd_reg[MS_W-1:0] : '0;
        // x * 256000 = (x << 18) - (x << 12) - (x << 11)
        abs_ext     = NUM_W'(abs_reg);
        mag_next    = (abs_ext << 18) - (abs_ext << 12) - (abs_ext << 11);
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= ring_mem[ptr_reg];
        if (cmd.update)
        begin
            ring_mem[ptr_reg] <= {delta, ms_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            full_reg       <= 1'b0;
            last_count_reg <= '0;
            tick_sum_reg   <= '0;
            time_sum_reg   <= '0;
        end
        else
        begin
            if (cmd.capture && (in_data.command == CMD_RESET_POS))
            begin
                last_count_reg <= '0;
            end
            if (cmd.update)
            begin
                last_count_reg <= count_reg;
                tick_sum_reg   <= tick_sum_reg + TICK_SUM_W'(delta)
                                  - TICK_SUM_W'(evict_delta);
                time_sum_reg   <= time_sum_reg + TIME_SUM_W'(ms_reg)
                                  - TIME_SUM_W'(evict_ms);
                if (ptr_reg == PTR_W'(WINDOW - 1))
                begin
                    ptr_reg  <= '0;
                    full_reg <= 1'b1;
                end
                else
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            count_reg <= in_data.encoder_count;
            ms_reg    <= in_data.elapsed_ms;
        end
        if (cmd.take_abs)
        begin
            neg_reg <= tick_sum_reg[TICK_SUM_W-1];
            abs_reg <= tick_sum_reg[TICK_SUM_W-1] ? TICK_SUM_W'(-tick_sum_reg)
                                                  : TICK_SUM_W'(tick_sum_reg);
        end
        if (cmd.scale)
        begin
            mag_reg <= mag_next;
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    ewv_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mag_reg),
        .divisor  (time_sum_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // sign, saturation and zero time sum
    always_comb
    begin
        if (neg_reg)
        begin
            if (quotient > NUM_W'({1'b0, VEL_MIN}))
            begin
                vel = VEL_MIN;
            end
            else
            begin
                vel = -VEL_W'(quotient);
            end
        end
        else
        begin
            if (quotient > NUM_W'(VEL_MAX))
            begin
                vel = VEL_MAX;
            end
            else
            begin
                vel = VEL_W'(quotient);
            end
        end

        out_next.velocity_valid = (time_sum_reg != '0);
        out_next.velocity_q8    = out_next.velocity_valid ? vel : '0;
        out_next.position_ticks = last_count_reg;
    end

    assign sts.div_busy = div_busy;
    assign out_data     = out_reg;

endmodule

/* hw/rtl/ewv_ctrl.sv */
module ewv_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          reset_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output ewv_pkg::cmd_t cmd,
    input  ewv_pkg::sts_t sts
);
    import ewv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_ABS,
        S_SCALE,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (reset_cmd == CMD_RESET_POS) ? S_ABS : S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                cmd.take_abs = 1'b1;
                state_next   = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/encoder_window_velocity.sv */
// channel   signals                       payload
// input     in_valid / in_ready           in_data  : command, encoder_count, elapsed_ms
// output    out_valid / out_ready         out_data : velocity_q8, velocity_valid,
//                                                    position_ticks
//
// one transaction in flight; the next input is taken in the cycle in which the result
// appears at the output, once the output register has taken it, which can stall on out_ready
// the 58-by-24-bit radix-4 divider (29 steps) takes the largest share of the work per item
// rst_n clears the sums, the ring pointer and fill flag; the ring needs no clearing pass
// the output register holds one result while the next item is taken and worked on
module encoder_window_velocity #(
    parameter int WINDOW = ewv_pkg::WINDOW_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ewv_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ewv_pkg::out_t out_data
);
    import ewv_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ewv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .reset_cmd (in_data.command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ewv_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

`ifndef SYNTHESIS
    a_busy_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_busy |-> !in_ready)
        else $error("input ready while divider busy");

    a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction taken while one is in flight");

    a_invalid_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.velocity_valid) |-> (out_data.velocity_q8 == '0))
        else $error("nonzero velocity with zero time sum");
`endif

endmodule

/* verif/encoder_window_velocity_tb.sv */
`timescale 1ns / 1ps

module encoder_window_velocity_tb;

    import ewv_pkg::*;

    localparam int     WIN         = WINDOW_DEFAULT;
    localparam int     N_DIRECTED  = 24;
    localparam int     PHASE_ITEMS = 300;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     HOLD_CYCLES = 400;
    localparam longint VEL_HI      = 64'sd549755813887;
    localparam longint VEL_LO      = -VEL_HI - 64'sd1;

    typedef struct {
        in_t  stim;
        bit   typed;
        out_t want;
    } stim_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    // predictor state
    logic signed [COUNT_W-1:0] pos_ref;
    logic signed [COUNT_W-1:0] win_delta [WIN];
    logic        [MS_W-1:0]    win_ms    [WIN];
    int                        win_ptr;
    longint                    win_ticks;
    int unsigned               win_ms_sum;

    out_t      pending_results [$];
    stim_row_t dir_rows [N_DIRECTED];
    int        failures      = 0;
    int        cycle_count   = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        zero_ms_run   = 0;
    bit        pressure_go   = 1'b0;
    logic      hold_off      = 1'b0;

    encoder_window_velocity i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    function automatic out_t estimate_velocity(in_t it);
        out_t                      r;
        logic signed [COUNT_W-1:0] step;
        longint                    q;
        if (it.command == CMD_RESET_POS) begin
            pos_ref = '0;
        end
        else begin
            step       = it.encoder_count - pos_ref;
            pos_ref    = it.encoder_count;
            win_ticks  = win_ticks + longint'(step) - longint'(win_delta[win_ptr]);
            win_ms_sum = win_ms_sum + it.elapsed_ms - win_ms[win_ptr];
            win_delta[win_ptr] = step;
            win_ms[win_ptr]    = it.elapsed_ms;
            win_ptr    = (win_ptr + 1) % WIN;
        end
        q = 0;
        if (win_ms_sum != 0) begin
            q = (win_ticks * 64'sd256000) / longint'(win_ms_sum);
            if (q > VEL_HI)
                q = VEL_HI;
            if (q < VEL_LO)
                q = VEL_LO;
        end
        r.velocity_q8    = q[VEL_W-1:0];
        r.velocity_valid = (win_ms_sum != 0);
        r.position_ticks = pos_ref;
        return r;
    endfunction

    function automatic in_t next_sample();
        in_t                       it;
        int                        pick;
        logic signed [COUNT_W-1:0] step;
        pick             = $urandom_range(99);
        it.command       = CMD_SAMPLE;
        it.encoder_count = $urandom;
        it.elapsed_ms    = MS_W'($urandom);
        if (zero_ms_run > 0) begin
            zero_ms_run      = zero_ms_run - 1;
            it.encoder_count = pos_ref + ($urandom_range(400) - 200);
            it.elapsed_ms    = '0;
        end
        else if (pick < 6) begin
            it.command = CMD_RESET_POS;
        end
        else if (pick < 14) begin
            // arbitrary count and time
        end
        else if (pick < 15) begin
            zero_ms_run = WIN + 1;
        end
        else begin
            pick = $urandom_range(99);
            if (pick < 70)
                step = $urandom_range(2000) - 1000;
            else if (pick < 90)
                step = {{16{1'b0}}, 16'($urandom)} - 32'sd32768;
            else
                step = $urandom;
            it.encoder_count = pos_ref + step;
            pick = $urandom_range(99);
            if (pick < 80)
                it.elapsed_ms = MS_W'($urandom_range(50, 1));
            else if (pick < 90)
                it.elapsed_ms = '0;
        end
        return it;
    endfunction

    task automatic send_item(in_t item, bit typed, out_t want);
        out_t r;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        r = estimate_velocity(item);
        pending_results.insert(pending_results.size(), typed ? want : r);
    endtask

    always @(posedge clk)
    begin
        out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction %h", $time, out_data);
                failures++;
            end
            else begin
                want = pending_results.pop_front();
                if (out_data.velocity_q8 !== want.velocity_q8) begin
                    $display("%0t: velocity_q8 expected %0d actual %0d",
                             $time, want.velocity_q8, out_data.velocity_q8);
                    failures++;
                end
                if (out_data.velocity_valid !== want.velocity_valid) begin
                    $display("%0t: velocity_valid expected %0b actual %0b",
                             $time, want.velocity_valid, out_data.velocity_valid);
                    failures++;
                end
                if (out_data.position_ticks !== want.position_ticks) begin
                    $display("%0t: position_ticks expected %0d actual %0d",
                             $time, want.position_ticks, out_data.position_ticks);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        logic signed [COUNT_W-1:0] cnt;
        int                        n;

        pos_ref    = '0;
        win_ptr    = 0;
        win_ticks  = 0;
        win_ms_sum = 0;
        for (int k = 0; k < WIN; k++) begin
            win_delta[k] = '0;
            win_ms[k]    = '0;
        end

        // directed table
        foreach (dir_rows[k]) begin
            dir_rows[k].stim.command = CMD_SAMPLE;
            dir_rows[k].stim.elapsed_ms = '0;
            dir_rows[k].typed = 1'b0;
            dir_rows[k].want  = '0;
        end
        // reset command right after reset, fields ignored
        dir_rows[0].stim = '{CMD_RESET_POS, 32'sh1234_5678, 16'hFFFF};
        dir_rows[0].typed = 1'b1;
        dir_rows[0].want  = '{'0, 1'b0, '0};
        // zero time sum
        dir_rows[1].stim = '{CMD_SAMPLE, 32'sh0000_0000, 16'h0000};
        dir_rows[1].typed = 1'b1;
        dir_rows[1].want  = '{'0, 1'b0, '0};
        // negative saturation
        dir_rows[2].stim = '{CMD_SAMPLE, 32'sh8000_0000, 16'h0001};
        dir_rows[2].typed = 1'b1;
        dir_rows[2].want  = '{VEL_MIN, 1'b1, 32'sh8000_0000};
        dir_rows[3].stim = '{CMD_RESET_POS, 32'shFFFF_FFFF, 16'h0000};
        dir_rows[4].stim = '{CMD_SAMPLE, 32'sh7FFF_FFFF, 16'h0000};
        // count wrap both ways
        dir_rows[5].stim = '{CMD_SAMPLE, 32'sh8000_0010, 16'hFFFF};
        dir_rows[6].stim = '{CMD_SAMPLE, 32'sh7FFF_FFF8, 16'h0000};
        // flush the window with zero time entries
        cnt = 32'sh7FFF_FFF8;
        for (int k = 7; k < 23; k++) begin
            cnt = cnt + 32'sd100;
            dir_rows[k].stim = '{CMD_SAMPLE, cnt, 16'h0000};
        end
        dir_rows[22].typed = 1'b1;
        dir_rows[22].want  = '{'0, 1'b0, cnt};
        // positive saturation
        cnt = cnt + 32'sh7FFF_FFFF;
        dir_rows[23].stim = '{CMD_SAMPLE, cnt, 16'h0001};
        dir_rows[23].typed = 1'b1;
        dir_rows[23].want  = '{VEL_MAX, 1'b1, cnt};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
            send_item(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].want);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            n = PHASE_ITEMS + $urandom_range(20);
            repeat (n) send_item(next_sample(), 1'b0, '0);
        end

        // receiver held off while the sender keeps offering
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_go    = 1'b1;
        repeat (60) send_item(next_sample(), 1'b0, '0);

        send_idle_pct  = 20;
        recv_stall_pct = 20;
        repeat (40) send_item(next_sample(), 1'b0, '0);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (failures == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
